/* hw/rtl/lcfb_pkg.sv */
package lcfb_pkg;

	localparam logic [7:0]  START_BYTE = 8'h26;
	localparam logic [15:0] CRC_POLY   = 16'h1021;
	localparam int          MAX_BYTES  = 8;
	localparam int          IDX_W      = $clog2(MAX_BYTES);
	localparam logic [IDX_W-1:0] HDR_BYTES = IDX_W'(5);

	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [IDX_W-1:0]          last_idx;
		logic                      ends_frame;
	} bundle_t;

	typedef struct packed {
		logic    valid;
		bundle_t bundle;
	} stage_t;

	// one byte of CRC-16/XMODEM, MSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* hw/rtl/lcfb_byte_if.sv */
interface lcfb_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

/* hw/rtl/lcfb_frame_if.sv */
interface lcfb_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       frame_last;

	modport source (output valid, output out_byte, output run_last, output frame_last,
		input ready);
	modport sink (input valid, input out_byte, input run_last, input frame_last,
		output ready);
endinterface

/* hw/rtl/lcfb_cfg_if.sv */
interface lcfb_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] payload_length;

	modport source (output valid, output payload_length, input ready);
	modport sink (input valid, input payload_length, output ready);
endinterface

/* hw/rtl/lcfb_framer.sv */
module lcfb_framer (
	input  logic                 clk,
	input  logic                 arst_n,
	lcfb_byte_if.sink            data_in,
	lcfb_cfg_if.sink             cfg,
	input  logic                 take,
	output lcfb_pkg::stage_t     stage
);

	logic [15:0]       payload_length_q;
	logic [15:0]       bytes_taken_q;
	logic [15:0]       running_crc_q;
	logic              valid_s1;
	lcfb_pkg::bundle_t bundle_s1;

	logic [15:0]       len;
	logic [15:0]       crc_next;
	logic              first;
	logic              ends;
	logic              accept;
	lcfb_pkg::bundle_t bundle_next;

	assign cfg.ready     = 1'b1;
	assign data_in.ready = !valid_s1 || take;
	assign accept        = data_in.valid && data_in.ready;

	always_comb begin
		len      = (payload_length_q == 16'd0) ? 16'd1 : payload_length_q;
		crc_next = lcfb_pkg::crc_byte(running_crc_q, data_in.data_byte);
		first    = (bytes_taken_q == 16'd0);
		ends     = ({1'b0, bytes_taken_q} + 17'd1) >= {1'b0, len};
		bundle_next = '0;
		if (first) begin
			bundle_next.bytes[0] = lcfb_pkg::START_BYTE;
			bundle_next.bytes[1] = len[7:0];
			bundle_next.bytes[2] = len[15:8];
			bundle_next.bytes[5] = data_in.data_byte;
			bundle_next.bytes[6] = crc_next[7:0];
			bundle_next.bytes[7] = crc_next[15:8];
		end else begin
			bundle_next.bytes[0] = data_in.data_byte;
			bundle_next.bytes[1] = crc_next[7:0];
			bundle_next.bytes[2] = crc_next[15:8];
		end
		bundle_next.last_idx   = (first ? lcfb_pkg::HDR_BYTES : '0)
			+ (ends ? lcfb_pkg::IDX_W'(2) : '0);
		bundle_next.ends_frame = ends;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_length_q <= 16'd1;
			bytes_taken_q    <= '0;
			running_crc_q    <= '0;
			valid_s1         <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				payload_length_q <= cfg.payload_length;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
				if (ends) begin
					bytes_taken_q <= '0;
					running_crc_q <= '0;
				end else begin
					bytes_taken_q <= bytes_taken_q + 16'd1;
					running_crc_q <= crc_next;
				end
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bundle_s1 <= bundle_next;
		end
	end

	assign stage.valid  = valid_s1;
	assign stage.bundle = bundle_s1;

endmodule

/* hw/rtl/lcfb_serializer.sv */
module lcfb_serializer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lcfb_pkg::stage_t     stage,
	output logic                 take,
	lcfb_frame_if.source         frame_out
);

	logic                          valid_s2;
	lcfb_pkg::bundle_t             bundle_s2;
	logic [lcfb_pkg::IDX_W-1:0]    idx_q;
	logic                          at_last;
	logic                          done;

	assign at_last = (idx_q == bundle_s2.last_idx);
	assign done    = frame_out.valid && frame_out.ready && at_last;
	assign take    = stage.valid && (!valid_s2 || done);

	assign frame_out.valid      = valid_s2;
	assign frame_out.out_byte   = bundle_s2.bytes[idx_q];
	assign frame_out.run_last   = at_last;
	assign frame_out.frame_last = at_last && bundle_s2.ends_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (take) begin
				valid_s2 <= 1'b1;
				idx_q    <= '0;
			end else if (done) begin
				valid_s2 <= 1'b0;
				idx_q    <= '0;
			end else if (frame_out.valid && frame_out.ready) begin
				idx_q <= idx_q + lcfb_pkg::IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			bundle_s2 <= stage.bundle;
		end
	end

endmodule

/* hw/rtl/length_crc_frame_builder.sv */
// Frames a payload byte stream: start byte 0x26, 4-byte little-endian length
// (from payload_length, 0 treated as 1), payload, then CRC-16/XMODEM low byte
// first. Each input word is turned into a group of 1 to 8 output words, which
// is registered in a holding stage; a second stage sends the group out one
// word per cycle while the output is ready. The output channel sets the rate:
// an input word gives 1 output word mid-frame, 3 for the byte that ends a
// frame, 6 for the first byte of a frame and 8 for a one-byte frame, and the
// next input word is taken in the cycle the holding stage hands its group on,
// so mid-frame bytes flow at one word per cycle while the output is ready.
// Write payload_length only while the block is idle.
module length_crc_frame_builder (
	input  logic          clk,
	input  logic          arst_n,
	lcfb_byte_if.sink     data_in,
	lcfb_cfg_if.sink      cfg,
	lcfb_frame_if.source  frame_out
);

	lcfb_pkg::stage_t stage;
	logic             take;

	lcfb_framer u_framer (
		.clk     (clk),
		.arst_n  (arst_n),
		.data_in (data_in),
		.cfg     (cfg),
		.take    (take),
		.stage   (stage)
	);

	lcfb_serializer u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.stage     (stage),
		.take      (take),
		.frame_out (frame_out)
	);

endmodule
